>>> src/biq_pkg.sv
package biq_pkg;

	// Channel store
	localparam int CHANNELS = 64;
	localparam int CH_W     = 6;
	localparam int ADDR_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	// Sample and coefficient widths (Q2.16 coefficients)
	localparam int SAMPLE_W = 16;
	localparam int COEF_W   = 18;
	localparam int PROD_W   = COEF_W + SAMPLE_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int FRAC_W   = 16;

	// One history entry: two samples for x, two for y
	localparam int HALF_W   = 2 * SAMPLE_W;
	localparam int HIST_W   = 2 * HALF_W;

	// Register map
	localparam int IDX_W    = 3;

	typedef enum logic [IDX_W-1:0] {
		REG_B0 = 3'd0,
		REG_B1 = 3'd1,
		REG_B2 = 3'd2,
		REG_A1 = 3'd3,
		REG_A2 = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic signed [COEF_W-1:0] b0;
		logic signed [COEF_W-1:0] b1;
		logic signed [COEF_W-1:0] b2;
		logic signed [COEF_W-1:0] a1;
		logic signed [COEF_W-1:0] a2;
	} coef_t;

	// Load enables for the arithmetic pipeline
	typedef struct packed {
		logic en_s2;
		logic en_s3;
	} mac_ctl_t;

endpackage

>>> src/biq_ram.sv
module biq_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read, holds when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/biq_mac.sv
module biq_mac (
	input  logic                                    clk,
	input  biq_pkg::mac_ctl_t                       ctl,
	input  biq_pkg::coef_t                          coef,
	input  logic signed [biq_pkg::SAMPLE_W-1:0]     x0,
	input  logic signed [biq_pkg::SAMPLE_W-1:0]     x1,
	input  logic signed [biq_pkg::SAMPLE_W-1:0]     x2,
	input  logic signed [biq_pkg::SAMPLE_W-1:0]     y1,
	input  logic signed [biq_pkg::SAMPLE_W-1:0]     y2,
	output logic signed [biq_pkg::SAMPLE_W-1:0]     q,
	output logic                                    clip
);

	localparam int RND_W = biq_pkg::ACC_W + 1;
	localparam int Q_W   = RND_W - biq_pkg::FRAC_W;

	logic signed [biq_pkg::PROD_W-1:0] pb0_s2, pb1_s2, pb2_s2, pa1_s2, pa2_s2;
	logic signed [biq_pkg::ACC_W-1:0]  acc_s3;
	logic signed [RND_W-1:0]           rnd;
	logic signed [Q_W-1:0]             qw;

	// Stage 2: five products
	always_ff @(posedge clk) begin
		if (ctl.en_s2) begin
			pb0_s2 <= coef.b0 * x0;
			pb1_s2 <= coef.b1 * x1;
			pb2_s2 <= coef.b2 * x2;
			pa1_s2 <= coef.a1 * y1;
			pa2_s2 <= coef.a2 * y2;
		end
	end

	// Stage 3: accumulate
	always_ff @(posedge clk) begin
		if (ctl.en_s3) begin
			acc_s3 <= biq_pkg::ACC_W'(pb0_s2) + biq_pkg::ACC_W'(pb1_s2)
				+ biq_pkg::ACC_W'(pb2_s2) - biq_pkg::ACC_W'(pa1_s2)
				- biq_pkg::ACC_W'(pa2_s2);
		end
	end

	// Round half up, then saturate to 16 bits
	always_comb begin
		rnd = RND_W'(acc_s3) + RND_W'(32768);
		qw  = rnd[RND_W-1:biq_pkg::FRAC_W];
		if (qw > Q_W'(32767)) begin
			q    = 16'sh7fff;
			clip = 1'b1;
		end else if (qw < -Q_W'(32768)) begin
			q    = 16'sh8000;
			clip = 1'b1;
		end else begin
			q    = qw[biq_pkg::SAMPLE_W-1:0];
			clip = 1'b0;
		end
	end

endmodule

>>> src/multichannel_biquad_iir_filter.sv
// One biquad section in direct form I shared by all channels, each channel keeping
// its last two inputs and outputs in a history RAM cleared at reset by per-entry
// valid bits (no clearing pass). A word is accepted every cycle as long as the
// output path is not stalled and its channel differs from those of the words still
// in the three stages behind the input; otherwise it waits until that word has
// written its history back. The spacing of words on one channel is set by the
// read-modify-write loop through the history RAM: RAM read, multiply, accumulate,
// round/saturate and write back. An accepted word passes stages 1, 2 and 3 and the
// output register before out_valid. Coefficients are signed Q2.16, written via
// cfg_we/cfg_index/cfg_data; the user must write them only while the block is
// idle, which the block does not enforce; indexes beyond coef_a2 are ignored. The
// output is rounded half up and saturated to 16 bits; clipped flags saturation.
module multichannel_biquad_iir_filter (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [biq_pkg::IDX_W-1:0]               cfg_index,
	input  logic [biq_pkg::COEF_W-1:0]              cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_stall,
	input  logic [biq_pkg::CH_W-1:0]                channel,
	input  logic signed [biq_pkg::SAMPLE_W-1:0]     sample_in,
	output logic                                    out_valid,
	input  logic                                    out_stall,
	output logic [biq_pkg::CH_W-1:0]                channel_out,
	output logic signed [biq_pkg::SAMPLE_W-1:0]     sample_out,
	output logic                                    clipped
);

	localparam int SW = biq_pkg::SAMPLE_W;
	localparam int AW = biq_pkg::ADDR_W;

	biq_pkg::coef_t    coef_q;
	biq_pkg::mac_ctl_t mac_ctl;

	logic                 v_s1, v_s2, v_s3, out_valid_q;
	logic                 take_s1, take_s2, take_s3, adv_out;
	logic                 in_acc, hazard, chan_ok;
	logic [biq_pkg::CH_W-1:0] ch_s1, ch_s2, ch_s3, channel_out_q;
	logic                 rng_s1, rng_s2, rng_s3, hist_ok_s1;
	logic signed [SW-1:0] x0_s1, x0_s2, x0_s3;
	logic signed [SW-1:0] x1_s2, x1_s3, y1_s2, y1_s3;
	logic signed [SW-1:0] hx1, hx2, hy1, hy2;
	logic signed [SW-1:0] q, sample_out_q;
	logic                 clip, clipped_q;
	logic [biq_pkg::CHANNELS-1:0] vld_q;
	logic [biq_pkg::HIST_W-1:0]   rdata, wdata;
	logic [AW-1:0]        raddr, waddr;
	logic                 we;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.b0 <= 18'sd65536;
			coef_q.b1 <= '0;
			coef_q.b2 <= '0;
			coef_q.a1 <= '0;
			coef_q.a2 <= '0;
		end else if (cfg_we) begin
			case (biq_pkg::reg_idx_t'(cfg_index))
				biq_pkg::REG_B0: coef_q.b0 <= cfg_data;
				biq_pkg::REG_B1: coef_q.b1 <= cfg_data;
				biq_pkg::REG_B2: coef_q.b2 <= cfg_data;
				biq_pkg::REG_A1: coef_q.a1 <= cfg_data;
				biq_pkg::REG_A2: coef_q.a2 <= cfg_data;
				default: ;
			endcase
		end
	end

	// Pipeline flow: each stage loads when it is empty or drains
	always_comb begin
		adv_out  = !out_valid_q || !out_stall;
		take_s3  = !v_s3 || adv_out;
		take_s2  = !v_s2 || take_s3;
		take_s1  = !v_s1 || take_s2;
		hazard   = (v_s1 && ch_s1 == channel) || (v_s2 && ch_s2 == channel)
			|| (v_s3 && ch_s3 == channel);
		in_stall = !take_s1 || hazard;
		in_acc   = in_valid && !in_stall;
		chan_ok  = int'(channel) < biq_pkg::CHANNELS;
		raddr    = AW'(channel);
		mac_ctl.en_s2 = take_s2;
		mac_ctl.en_s3 = take_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (take_s1) begin
				v_s1 <= in_acc;
			end
			if (take_s2) begin
				v_s2 <= v_s1;
			end
			if (take_s3) begin
				v_s3 <= v_s2;
			end
			if (adv_out) begin
				out_valid_q <= v_s3;
			end
		end
	end

	// Stage 1: word in, RAM read in flight
	always_ff @(posedge clk) begin
		if (take_s1) begin
			ch_s1      <= channel;
			x0_s1      <= sample_in;
			rng_s1     <= chan_ok;
			hist_ok_s1 <= chan_ok && vld_q[raddr];
		end
	end

	// History from RAM, zero when never written or channel out of range
	always_comb begin
		if (hist_ok_s1) begin
			hx1 = rdata[SW-1:0];
			hx2 = rdata[2*SW-1:SW];
			hy1 = rdata[3*SW-1:2*SW];
			hy2 = rdata[4*SW-1:3*SW];
		end else begin
			hx1 = '0;
			hx2 = '0;
			hy1 = '0;
			hy2 = '0;
		end
	end

	// Stages 2 and 3: carry what the write-back needs
	always_ff @(posedge clk) begin
		if (take_s2) begin
			ch_s2  <= ch_s1;
			rng_s2 <= rng_s1;
			x0_s2  <= x0_s1;
			x1_s2  <= hx1;
			y1_s2  <= hy1;
		end
		if (take_s3) begin
			ch_s3  <= ch_s2;
			rng_s3 <= rng_s2;
			x0_s3  <= x0_s2;
			x1_s3  <= x1_s2;
			y1_s3  <= y1_s2;
		end
	end

	biq_mac u_mac (
		.clk  (clk),
		.ctl  (mac_ctl),
		.coef (coef_q),
		.x0   (x0_s1),
		.x1   (hx1),
		.x2   (hx2),
		.y1   (hy1),
		.y2   (hy2),
		.q    (q),
		.clip (clip)
	);

	// Write-back as the word leaves stage 3
	always_comb begin
		we    = v_s3 && adv_out && rng_s3;
		waddr = AW'(ch_s3);
		wdata = {y1_s3, q, x1_s3, x0_s3};
	end

	biq_ram #(
		.WIDTH (biq_pkg::HIST_W),
		.DEPTH (biq_pkg::CHANNELS)
	) u_hist (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (in_acc),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Entry valid bits stand in for clearing the RAM
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (adv_out && v_s3) begin
			channel_out_q <= ch_s3;
			sample_out_q  <= q;
			clipped_q     <= clip;
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_out = channel_out_q;
	assign sample_out  = sample_out_q;
	assign clipped     = clipped_q;

`ifndef SYNTHESIS
	a_no_dup_s1_s2: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s2 |-> ch_s1 != ch_s2)
		else $error("same channel in stages 1 and 2");
	a_no_dup_s2_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 && v_s3 |-> ch_s2 != ch_s3)
		else $error("same channel in stages 2 and 3");
	a_no_dup_s1_s3: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && v_s3 |-> ch_s1 != ch_s3)
		else $error("same channel in stages 1 and 3");
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && clipped |-> sample_out == 16'sh7fff || sample_out == 16'sh8000)
		else $error("clipped word not at a rail");
`endif

endmodule
